// ===== rtl/pfa_pkg.sv =====
package pfa_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE = 1'b1;
  localparam logic [4:0]           PARTS_IN_USE_RST = 5'd9;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Job count saturation value
  localparam logic [3:0] COUNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    FIT_FIRST,
    FIT_NEXT,
    FIT_BEST,
    FIT_WORST
  } policy_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e_t;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  partition_index;
    logic [15:0] amount;
    logic [7:0]  job_id;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_partition;
    logic [15:0] space_left;
    logic [3:0]  jobs_in_partition;
    logic [7:0]  job_echo;
  } out_item_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic      wr;
    logic      load;
    policy_e_t policy;
  } cell_ctrl_t;

endpackage

// ===== rtl/pfa_cell.sv =====
module pfa_cell #(
  parameter int K  = 0,
  parameter int IW = 4,
  parameter int NW = 5,
  parameter int SW = 16,
  localparam int CW = 1 + IW + SW + 4,
  localparam int PW = 1 + 2 * CW
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pfa_pkg::cell_ctrl_t ctrl,
  input  logic [IW-1:0]       cmd_idx,
  input  logic [SW-1:0]       need,
  input  logic [NW-1:0]       scan_n,
  input  logic [IW-1:0]       scan_start,
  input  logic [PW-1:0]       probe_i,
  output logic [PW-1:0]       probe_o
);
  import pfa_pkg::*;

  typedef struct packed {
    logic          found;
    logic [IW-1:0] idx;
    logic [SW-1:0] val;
    logic [3:0]    cnt;
  } cand_t;

  typedef struct packed {
    logic  valid;
    cand_t a;
    cand_t b;
  } probe_t;

  logic [SW-1:0] fs_r, fs_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  probe_t        pin, probe_r, probe_nxt;
  logic          elig, after_start, hit;
  cand_t         mine;

  assign pin = probe_t'(probe_i);

  // State update on a commit addressed to this cell
  always_comb begin
    fs_nxt  = fs_r;
    cnt_nxt = cnt_r;
    hit     = ctrl.wr && (int'(cmd_idx) == K);
    if (hit) begin
      if (ctrl.load) begin
        fs_nxt  = need;
        cnt_nxt = '0;
      end else begin
        fs_nxt  = fs_r - need;
        cnt_nxt = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 4'd1;
      end
    end
  end

  // Fold this partition into the passing probe
  always_comb begin
    elig        = (K < int'(scan_n)) && (fs_r >= need);
    after_start = (K >= int'(scan_start));
    mine        = '{found: 1'b1, idx: IW'(K), val: fs_r, cnt: cnt_r};
    probe_nxt   = pin;
    case (ctrl.policy)
      FIT_FIRST, FIT_NEXT: begin
        if (elig && after_start && !pin.a.found) probe_nxt.a = mine;
        if (elig && !after_start && !pin.b.found) probe_nxt.b = mine;
      end
      FIT_BEST: begin
        if (elig && (!pin.a.found || fs_r < pin.a.val)) probe_nxt.a = mine;
      end
      FIT_WORST: begin
        if (elig && (!pin.a.found || fs_r > pin.a.val)) probe_nxt.a = mine;
      end
      default: probe_nxt = pin;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r          <= '0;
      cnt_r         <= '0;
      probe_r.valid <= 1'b0;
    end else begin
      fs_r          <= fs_nxt;
      cnt_r         <= cnt_nxt;
      probe_r.valid <= probe_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    probe_r.a <= probe_nxt.a;
    probe_r.b <= probe_nxt.b;
  end

  assign probe_o = PW'(probe_r);

endmodule

// ===== rtl/partition_fit_allocator_top.sv =====
// Channel  Ports                          Moves
// -------  -----------------------------  -------------------------------------
// in       in_valid/in_ready/in_data      load or allocate item
// out      out_valid/out_ready/out_data   one result item per input item
// cfg      cfg_we/cfg_index/cfg_wdata     fit policy, partitions in use
//
// A load item goes from accept to the commit state with no search. For an allocate
// item the search probe walks the cell row one partition per cycle; the probe
// leaving the row is latched, and then the pick is committed.
// The next item is accepted right after commit, while the result waits.
// Reset (rst_n low, synchronous) clears all partitions and the next pointer.
// A stalled result holds in the output register; a commit waits for it.
module partition_fit_allocator_top #(
  parameter int PARTITIONS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pfa_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pfa_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pfa_pkg::*;

  localparam int IW = $clog2(PARTITIONS);
  localparam int NW = $clog2(PARTITIONS + 1);
  localparam int SW = SIZE_BITS;
  localparam int CW = 1 + IW + SW + 4;
  localparam int PW = 1 + 2 * CW;

  typedef struct packed {
    logic          found;
    logic [IW-1:0] idx;
    logic [SW-1:0] val;
    logic [3:0]    cnt;
  } cand_t;

  typedef struct packed {
    logic  valid;
    cand_t a;
    cand_t b;
  } probe_t;

  // Configuration registers
  policy_e_t     fit_policy_r;
  logic [4:0]    parts_in_use_r;

  // Sequencer state
  state_e_t      state_r, state_nxt;
  in_item_t      item_r;
  logic [NW-1:0] n_r, n_nxt;
  logic [IW-1:0] start_r, start_nxt;
  logic [IW-1:0] np_r, np_nxt;
  logic          launch_r;
  probe_t        fin_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r;

  // Chain wiring
  logic [PW-1:0] probe_w [PARTITIONS+1];
  probe_t        probe_end;
  cell_ctrl_t    ctrl;
  logic [IW-1:0] cmd_idx;
  logic [SW-1:0] need;

  // Commit decode
  logic          accept, commit_fire, fin_take;
  logic          res_granted;
  logic [IW-1:0] res_idx;
  logic [SW-1:0] res_space;
  logic [3:0]    res_jobs;
  cand_t         sel;
  logic          load_ok;
  out_item_t     res_item;

  assign accept    = in_valid && in_ready;
  assign need      = SW'({{SW{1'b0}}, item_r.amount});
  assign probe_end = probe_t'(probe_w[PARTITIONS]);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r   <= FIT_FIRST;
      parts_in_use_r <= PARTS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_POLICY:   fit_policy_r   <= policy_e_t'(cfg_wdata[1:0]);
        CFG_PARTS_IN_USE: parts_in_use_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = (in_data.opcode == OP_ALLOC) ? ST_SCAN : ST_COMMIT;
      end
      ST_SCAN: begin
        if (probe_end.valid) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    fin_take    = 1'b0;
    commit_fire = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready    = 1'b1;
      ST_SCAN:   fin_take    = probe_end.valid;
      ST_COMMIT: commit_fire = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Clamp the search span and pick the next-fit start at accept
  always_comb begin
    if (int'(parts_in_use_r) > PARTITIONS) begin
      n_nxt = NW'(PARTITIONS);
    end else begin
      n_nxt = NW'(parts_in_use_r);
    end
    if (fit_policy_r == FIT_NEXT && int'(np_r) < int'(n_nxt)) begin
      start_nxt = np_r;
    end else begin
      start_nxt = '0;
    end
  end

  // Result of the step, from the latched probe or the load item
  always_comb begin
    load_ok     = int'(item_r.partition_index) < PARTITIONS;
    sel         = fin_r.a.found ? fin_r.a : fin_r.b;
    res_granted = 1'b0;
    res_idx     = '0;
    res_space   = '0;
    res_jobs    = '0;
    np_nxt      = np_r;
    if (item_r.opcode == OP_LOAD) begin
      if (load_ok) begin
        res_granted = 1'b1;
        res_idx     = IW'(32'(item_r.partition_index));
        res_space   = need;
      end
    end else if (sel.found) begin
      res_granted = 1'b1;
      res_idx     = sel.idx;
      res_space   = sel.val - need;
      res_jobs    = (sel.cnt == COUNT_MAX) ? sel.cnt : sel.cnt + 4'd1;
      if (fit_policy_r == FIT_NEXT) begin
        // advance past the pick, wrapping at the search span
        if (32'(sel.idx) + 32'd1 == 32'(n_r)) begin
          np_nxt = '0;
        end else begin
          np_nxt = IW'(32'(sel.idx) + 32'd1);
        end
      end
    end
    res_item.granted           = res_granted;
    res_item.chosen_partition  = 4'(32'(res_idx));
    res_item.space_left        = 16'({16'b0, res_space});
    res_item.jobs_in_partition = res_jobs;
    res_item.job_echo          = item_r.job_id;
  end

  // Drop the output once taken, load it on commit
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      np_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= accept && (in_data.opcode == OP_ALLOC);
      out_valid_r <= out_valid_nxt;
      if (commit_fire) np_r <= np_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r  <= in_data;
      n_r     <= n_nxt;
      start_r <= start_nxt;
    end
    if (fin_take) fin_r <= probe_end;
    if (commit_fire) out_r <= res_item;
  end

  // Commit command broadcast to the cell row
  assign ctrl.wr     = commit_fire && res_granted;
  assign ctrl.load   = (item_r.opcode == OP_LOAD);
  assign ctrl.policy = fit_policy_r;
  assign cmd_idx     = res_idx;

  // Inject the search probe at the head of the row
  assign probe_w[0] = {launch_r, {(PW-1){1'b0}}};

  for (genvar k = 0; k < PARTITIONS; k++) begin : g_cell
    pfa_cell #(
      .K  (k),
      .IW (IW),
      .NW (NW),
      .SW (SW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .cmd_idx    (cmd_idx),
      .need       (need),
      .scan_n     (n_r),
      .scan_start (start_r),
      .probe_i    (probe_w[k]),
      .probe_o    (probe_w[k+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The probe only runs while a search is under way
  a_launch_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |-> state_r == ST_SCAN)
    else $error("probe launched outside a search");

  a_probe_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    probe_end.valid |-> state_r == ST_SCAN)
    else $error("probe left the row outside a search");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_COMMIT)
    else $error("result appeared without a commit");

  a_pointer_moves_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(np_r) |-> $past(commit_fire) && $past(fit_policy_r) == FIT_NEXT)
    else $error("next pointer moved outside a next-fit commit");

  a_cell_write_granted: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr && !ctrl.load |-> fin_r.a.found || fin_r.b.found)
    else $error("allocation written without a candidate");

endmodule
